FILE: rtl/ras_pkg.sv
package ras_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 16;

	localparam int ANGLE_W    = 24;
	localparam int THETA_W    = 18;
	localparam int ALPHA_W    = 17;
	localparam int STEP_W     = 23;
	localparam int LINES_W    = 11;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 23;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int WIDE_W  = PROD_W + 1;

	// 180/pi in Q.32, rounded to nearest Q.FRAC_BITS
	localparam logic [63:0] RAD2DEG_Q32 = 64'd246083499208;
	localparam logic [MUL_B_W-1:0] RAD2DEG_K =
		MUL_B_W'((RAD2DEG_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

	localparam logic signed [WIDE_W-1:0] DEG_90       = WIDE_W'(64'd90 << FRAC_BITS);
	localparam logic signed [WIDE_W-1:0] WIDE_ANG_MAX = WIDE_W'(64'd8388607);
	localparam logic signed [WIDE_W-1:0] WIDE_ANG_MIN = -(WIDE_W'(64'd8388608));

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FILTER_MIN = 3'd0,
		REG_FILTER_MAX = 3'd1,
		REG_ALPHA      = 3'd2,
		REG_DECAY      = 3'd3,
		REG_MAX_STEP   = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONV,
		S_ACC,
		S_DECM,
		S_DEC,
		S_DIV,
		S_BLA,
		S_BLB,
		S_BLC,
		S_FIN
	} state_t;

	typedef logic signed [MUL_A_W-1:0] mul_a_t;
	typedef logic signed [MUL_B_W-1:0] mul_b_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;

endpackage

FILE: rtl/ras_mul.sv
module ras_mul (
	input  logic           clk,
	input  ras_pkg::mul_a_t a,
	input  ras_pkg::mul_b_t b,
	output ras_pkg::prod_t  p_q
);
	import ras_pkg::*;

	// single signed multiplier, product registered
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

FILE: rtl/ras_div.sv
module ras_div #(
	parameter int SUM_W = 35,
	parameter int CNT_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output logic                    done,
	output ras_pkg::angle_t         quotient
);
	import ras_pkg::*;

	localparam int ITER_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic              neg_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  dsr_q;

	logic [SUM_W-1:0]  mag;
	logic [CNT_W:0]    trial;
	logic              ge;
	logic [ANGLE_W-1:0] qmag;

	assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign trial = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	// restoring divide, one quotient bit per cycle shifted into the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (busy_q) begin
			iter_q <= ITER_W'(iter_q + 1'b1);
			if (iter_q == ITER_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			dvd_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, dsr_q}) : trial;
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
		end
	end

	assign qmag     = dvd_q[ANGLE_W-1:0];
	assign quotient = neg_q ? angle_t'(-qmag) : angle_t'(qmag);
	assign done     = done_q;

endmodule

FILE: rtl/roll_angle_smoother.sv
// Frame-wise roll angle smoother.
// s_axis carries one word per detected line (tuser = 0, tdata = theta in
// unsigned Q2.16 radians) or an end-of-frame marker (tuser = 1, tdata ignored).
// Each line is converted to signed Q8.16 degrees and summed if it falls in
// [filter_min, filter_max]; lines past MAX_LINES are dropped and flagged.
// An end-of-frame word yields one m_axis word: the new smoothed angle,
// the number of lines used and the decayed / step_clamped / lines_dropped
// flags. Line words yield nothing.
// A line word is accepted, multiplied and accumulated before the next word is taken.
// An empty frame runs one decay multiply before its result.
// A non-empty frame runs a bit-serial divide over the SUM_W = 24 + clog2(MAX_LINES+1)
// bit sum (35 bits at the default), then two blend multiplies.
// All products share one 25x23 multiplier; the divide sets the frame-end time.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver blocks the next end-of-frame
// result and the words behind it. Reset restores the register defaults and clears sum,
// count and angle. Registers are written through cfg_we/cfg_addr/cfg_wdata; the user
// must write them only while idle, which the block itself does not enforce.
module roll_angle_smoother #(
	parameter int MAX_LINES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ras_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [ras_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [23:0]                      s_axis_tdata,  // [17:0] theta
	input  logic [0:0]                       s_axis_tuser,  // [0] req_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [39:0]                      m_axis_tdata,  // [23:0] smoothed_angle, [34:24] lines_used
	output logic [2:0]                       m_axis_tuser   // [0] decayed, [1] step_clamped, [2] lines_dropped
);
	import ras_pkg::*;

	localparam int CNT_W = $clog2(MAX_LINES + 1);
	localparam int SUM_W = ANGLE_W + CNT_W;
	localparam int EXT_W = CNT_W + LINES_W;

	state_t state_q, state_d;

	// configuration
	angle_t             fmin_q, fmax_q;
	logic [ALPHA_W-1:0] alpha_q, decay_q;
	logic [STEP_W-1:0]  mstep_q;

	// frame state
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;
	angle_t                  cur_q;

	// work registers
	logic [THETA_W-1:0] theta_q;
	angle_t             mean_q;
	prod_t              p1_q;
	angle_t             next_q;
	logic               decayed_q;

	// output register
	logic               out_valid_q;
	angle_t             out_angle_q;
	logic [LINES_W-1:0] out_lines_q;
	logic               out_dec_q, out_clamp_q, out_drop_q;

	mul_a_t mul_a;
	mul_b_t mul_b;
	prod_t  mul_p;
	logic   div_start, div_done;
	angle_t div_quot;

	logic in_acc, fin_go;

	function automatic logic signed [WIDE_W-1:0] trunc_w(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] sh;
		sh = v >>> WEIGHT_BITS;
		if (v[WIDE_W-1] && (|v[WEIGHT_BITS-1:0]))
			sh = sh + 1'b1;
		return sh;
	endfunction

	function automatic angle_t sat_ang(input logic signed [WIDE_W-1:0] v);
		angle_t r;
		if (v > WIDE_ANG_MAX)
			r = angle_t'(WIDE_ANG_MAX);
		else if (v < WIDE_ANG_MIN)
			r = angle_t'(WIDE_ANG_MIN);
		else
			r = angle_t'(v);
		return r;
	endfunction

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

	// line conversion: theta * K >> FRAC_BITS, minus 90 degrees
	logic signed [WIDE_W-1:0] deg_w;
	angle_t                   ang_a;
	logic                     in_win;

	assign deg_w  = $signed({{(WIDE_W-32){1'b0}}, mul_p[PROD_W-1:16]}) - DEG_90;
	assign ang_a  = sat_ang(deg_w);
	assign in_win = (ang_a >= fmin_q) && (ang_a <= fmax_q);

	// blend / decay
	logic signed [17:0]       wgt;
	logic signed [WIDE_W-1:0] blend_w;
	angle_t                   blend_next, dec_next;

	assign wgt        = $signed(18'd65536) - $signed({1'b0, alpha_q});
	assign blend_w    = $signed({p1_q[PROD_W-1], p1_q}) + $signed({mul_p[PROD_W-1], mul_p});
	assign blend_next = sat_ang(trunc_w(blend_w));
	assign dec_next   = sat_ang(trunc_w($signed({mul_p[PROD_W-1], mul_p})));

	// rate limit
	logic signed [WIDE_W-1:0] cur_w, nxt_w, ms_w, diff_w;
	logic                     clamp_hi, clamp_lo;
	angle_t                   final_ang;

	assign cur_w    = {{(WIDE_W-ANGLE_W){cur_q[ANGLE_W-1]}}, cur_q};
	assign nxt_w    = {{(WIDE_W-ANGLE_W){next_q[ANGLE_W-1]}}, next_q};
	assign ms_w     = {{(WIDE_W-STEP_W){1'b0}}, mstep_q};
	assign diff_w   = nxt_w - cur_w;
	assign clamp_hi = !decayed_q && (mstep_q != '0) && (diff_w > ms_w);
	assign clamp_lo = !decayed_q && (mstep_q != '0) && (diff_w < -ms_w);

	always_comb begin
		priority if (clamp_hi)
			final_ang = sat_ang(cur_w + ms_w);
		else if (clamp_lo)
			final_ang = sat_ang(cur_w - ms_w);
		else
			final_ang = next_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					priority if (!s_axis_tuser[0])
						state_d = S_CONV;
					else if (cnt_q == '0)
						state_d = S_DECM;
					else begin
						div_start = 1'b1;
						state_d   = S_DIV;
					end
				end
			end
			S_CONV: begin
				mul_a   = {{(MUL_A_W-THETA_W){1'b0}}, theta_q};
				mul_b   = RAD2DEG_K;
				state_d = S_ACC;
			end
			S_ACC: state_d = S_IDLE;
			S_DECM: begin
				mul_a   = {cur_q[ANGLE_W-1], cur_q};
				mul_b   = {{(MUL_B_W-ALPHA_W){1'b0}}, decay_q};
				state_d = S_DEC;
			end
			S_DEC: state_d = S_FIN;
			S_DIV: begin
				if (div_done)
					state_d = S_BLA;
			end
			S_BLA: begin
				mul_a   = {mean_q[ANGLE_W-1], mean_q};
				mul_b   = {{(MUL_B_W-ALPHA_W){1'b0}}, alpha_q};
				state_d = S_BLB;
			end
			S_BLB: begin
				mul_a   = {cur_q[ANGLE_W-1], cur_q};
				mul_b   = {{(MUL_B_W-18){wgt[17]}}, wgt};
				state_d = S_BLC;
			end
			S_BLC: state_d = S_FIN;
			S_FIN: begin
				if (fin_go)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	ras_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	ras_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// configuration and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmin_q  <= angle_t'(-24'sd2949120);
			fmax_q  <= angle_t'(24'sd2949120);
			alpha_q <= ALPHA_W'(6554);
			decay_q <= ALPHA_W'(62259);
			mstep_q <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			cur_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_FILTER_MIN: fmin_q  <= angle_t'(cfg_wdata);
					REG_FILTER_MAX: fmax_q  <= angle_t'(cfg_wdata);
					REG_ALPHA:      alpha_q <= cfg_wdata[ALPHA_W-1:0];
					REG_DECAY:      decay_q <= cfg_wdata[ALPHA_W-1:0];
					REG_MAX_STEP:   mstep_q <= cfg_wdata[STEP_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_ACC && in_win) begin
				if (cnt_q == CNT_W'(MAX_LINES)) begin
					ovf_q <= 1'b1;
				end else begin
					sum_q <= sum_q + {{(SUM_W-ANGLE_W){ang_a[ANGLE_W-1]}}, ang_a};
					cnt_q <= CNT_W'(cnt_q + 1'b1);
				end
			end
			if (fin_go) begin
				cur_q <= final_ang;
				sum_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (in_acc)
			theta_q <= s_axis_tdata[THETA_W-1:0];
		if (div_done)
			mean_q <= div_quot;
		if (state_q == S_BLB)
			p1_q <= mul_p;
		if (state_q == S_DEC) begin
			next_q    <= dec_next;
			decayed_q <= 1'b1;
		end
		if (state_q == S_BLC) begin
			next_q    <= blend_next;
			decayed_q <= 1'b0;
		end
	end

	// output register
	logic [EXT_W-1:0] cnt_ext;
	assign cnt_ext = EXT_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_go)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_angle_q <= final_ang;
			out_lines_q <= cnt_ext[LINES_W-1:0];
			out_dec_q   <= decayed_q;
			out_clamp_q <= clamp_hi || clamp_lo;
			out_drop_q  <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_lines_q, out_angle_q};
	assign m_axis_tuser  = {out_drop_q, out_clamp_q, out_dec_q};

	// checks
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_LINES))
		else $error("line count above capacity");

	a_line_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !s_axis_tuser[0]) |=> !$rose(m_axis_tvalid))
		else $error("line word produced a result");

	a_decay_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[34:24] == '0 && !m_axis_tuser[1]))
		else $error("decayed frame with lines or clamp");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divide finished outside divide wait");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (state_q == S_IDLE && m_axis_tvalid))
		else $error("result not presented after frame end");

endmodule

FILE: verif/roll_angle_smoother_test.sv
`timescale 1ns / 1ps

module roll_angle_smoother_test;
	import ras_pkg::*;

	localparam bit      LINE_WORD     = 1'b0;
	localparam bit      FRAME_END     = 1'b1;
	localparam int      LINE_CAP      = 1024;
	localparam longint  DEG_PER_RAD_Q = (64'd246083499208 + (64'd1 << 15)) >> 16;
	localparam longint  UNITY_Q16     = 65536;
	localparam longint  DEG90_Q16     = 90 * 65536;
	localparam longint  ANG_HI        = 8388607;
	localparam longint  ANG_LO        = -8388608;
	localparam int      SETTLE_CYCLES = 60;
	localparam int      CYCLE_LIMIT   = 600000;
	localparam int      REPORT_MAX    = 10;

	typedef struct {
		logic [23:0] angle;
		logic [10:0] used;
		logic        decayed;
		logic        clamped;
		logic        dropped;
	} frame_sum_t;

	class roll_frame_board;
		longint     win_lo, win_hi, alpha, decay, step_lim;
		longint     angle_sum, angle_now;
		int         line_cnt;
		bit         lost_lines;
		frame_sum_t frame_sums_q[$];
		int         errors;

		function new();
			win_lo     = -2949120;
			win_hi     = 2949120;
			alpha      = 6554;
			decay      = 62259;
			step_lim   = 0;
			angle_sum  = 0;
			angle_now  = 0;
			line_cnt   = 0;
			lost_lines = 0;
			errors     = 0;
		endfunction

		function int open_frames();
			return frame_sums_q.size();
		endfunction

		function longint clip24(longint v);
			if (v > ANG_HI) return ANG_HI;
			if (v < ANG_LO) return ANG_LO;
			return v;
		endfunction

		function longint theta_deg(logic [17:0] th);
			longint p;
			p = (longint'(th) * DEG_PER_RAD_Q) >>> 16;
			return clip24(p - DEG90_Q16);
		endfunction

		function void set_reg(cfg_reg_t idx, logic [23:0] v);
			case (idx)
				REG_FILTER_MIN: win_lo = longint'(signed'(v));
				REG_FILTER_MAX: win_hi = longint'(signed'(v));
				REG_ALPHA:      alpha = longint'(v[16:0]);
				REG_DECAY:      decay = longint'(v[16:0]);
				REG_MAX_STEP:   step_lim = longint'(v[22:0]);
				default: ;
			endcase
		endfunction

		function void take_word(bit kind, logic [17:0] th);
			longint     a, mean, blend, nxt, diff;
			frame_sum_t r;
			if (kind == LINE_WORD) begin
				a = theta_deg(th);
				if (a >= win_lo && a <= win_hi) begin
					if (line_cnt >= LINE_CAP) begin
						lost_lines = 1'b1;
					end else begin
						angle_sum += a;
						line_cnt++;
					end
				end
				return;
			end
			r.decayed = 1'b0;
			r.clamped = 1'b0;
			if (line_cnt == 0) begin
				nxt = clip24((angle_now * decay) / UNITY_Q16);
				r.decayed = 1'b1;
			end else begin
				mean  = angle_sum / longint'(line_cnt);
				blend = alpha * mean + (UNITY_Q16 - alpha) * angle_now;
				nxt   = clip24(blend / UNITY_Q16);
				diff  = nxt - angle_now;
				if (step_lim != 0) begin
					if (diff > step_lim) begin
						nxt = clip24(angle_now + step_lim);
						r.clamped = 1'b1;
					end else if (diff < -step_lim) begin
						nxt = clip24(angle_now - step_lim);
						r.clamped = 1'b1;
					end
				end
			end
			angle_now = nxt;
			r.angle   = nxt[23:0];
			r.used    = line_cnt[10:0];
			r.dropped = lost_lines;
			frame_sums_q.push_back(r);
			angle_sum  = 0;
			line_cnt   = 0;
			lost_lines = 1'b0;
		endfunction

		function void check_frame(logic [39:0] data, logic [2:0] flags);
			frame_sum_t e;
			if (frame_sums_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: unexpected result word angle %0d used %0d flags %b",
						$time, $signed(data[23:0]), data[34:24], flags);
				return;
			end
			e = frame_sums_q.pop_front();
			if (data[23:0] !== e.angle || data[34:24] !== e.used || flags[0] !== e.decayed
					|| flags[1] !== e.clamped || flags[2] !== e.dropped) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: result mismatch: exp angle %0d used %0d dec %b clamp %b drop %b, got angle %0d used %0d dec %b clamp %b drop %b",
						$time, $signed(e.angle), e.used, e.decayed, e.clamped, e.dropped,
						$signed(data[23:0]), data[34:24], flags[0], flags[1], flags[2]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [23:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [17:0] theta
	logic [0:0]  s_axis_tuser;   // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [23:0] smoothed_angle, [34:24] lines_used
	logic [2:0]  m_axis_tuser;   // [0] decayed, [1] step_clamped, [2] lines_dropped

	roll_frame_board board = new();
	int send_idle_pct;
	int recv_stall_pct;
	int cycles;

	roll_angle_smoother i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("roll_angle_smoother_test: done, errors");
		$finish;
	end

	// result side: check accepted words, then pick next tready
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				board.check_frame(m_axis_tdata, m_axis_tuser);
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_word(input bit kind, input logic [17:0] th);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, th};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		board.take_word(kind, th);
	endtask

	// always waits at least one edge so tvalid is never lowered and raised in one step
	task automatic hold_until_drained(input int settle);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.open_frames() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic load_config(input longint lo, input longint hi, input longint al,
			input longint dc, input longint st);
		logic [23:0] vals [5];
		hold_until_drained(SETTLE_CYCLES);
		vals[0] = lo[23:0];
		vals[1] = hi[23:0];
		vals[2] = al[23:0];
		vals[3] = dc[23:0];
		vals[4] = st[23:0];
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= cfg_reg_t'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			board.set_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly plausible angles, some near the window edges, some over the full field
	function automatic logic [17:0] pick_theta();
		longint t;
		case ($urandom_range(9))
			0, 1: return 18'($urandom_range(262143));
			2, 3: begin
				t = ((($urandom_range(1) ? board.win_lo : board.win_hi) + DEG90_Q16) << 16)
					/ DEG_PER_RAD_Q;
				t = t + $urandom_range(4) - 2;
				if (t < 0) t = 0;
				if (t > 262143) t = 262143;
				return t[17:0];
			end
			default: return 18'($urandom_range(205887));
		endcase
	endfunction

	task automatic run_frames(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
			repeat (len) send_word(LINE_WORD, pick_theta());
			send_word(FRAME_END, 18'($urandom_range(262143)));
			sent += len + 1;
		end
	endtask

	task automatic run_directed();
		send_word(LINE_WORD, 18'd0);
		send_word(LINE_WORD, 18'd51472);
		send_word(LINE_WORD, 18'd102944);
		send_word(LINE_WORD, 18'd154416);
		send_word(LINE_WORD, 18'd205887);
		send_word(LINE_WORD, 18'h3FFFF);
		send_word(FRAME_END, 18'h3FFFF);
		send_word(FRAME_END, 18'd0);
		// full window, full weight, tight step: expect a clamped step
		load_config(-5898240, 5898240, 65536, 0, 65536);
		send_word(LINE_WORD, 18'd205887);
		send_word(LINE_WORD, 18'h3FFFF);
		send_word(FRAME_END, 18'd0);
		send_word(FRAME_END, 18'd0);
		send_word(LINE_WORD, 18'd0);
		send_word(FRAME_END, 18'd0);
		// min above max: nothing gets in
		load_config(65536, -65536, 32768, 65536, 0);
		send_word(LINE_WORD, 18'd102944);
		send_word(LINE_WORD, 18'd110000);
		send_word(FRAME_END, 18'd0);
		load_config(-5898240, 5898240, 6554, 62259, 0);
		send_word(LINE_WORD, 18'd102944);
		send_word(FRAME_END, 18'd0);
	endtask

	initial begin
		longint cfg_tab [6][5];
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_addr       = REG_FILTER_MIN;
		cfg_wdata      = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		send_idle_pct  = 10;
		recv_stall_pct = 83;

		cfg_tab[0] = '{-2949120, 2949120, 6554, 62259, 0};
		cfg_tab[1] = '{-8388608, 8388607, 131071, 131071, 8388607};
		cfg_tab[2] = '{-5898240, 5898240, 65536, 65536, 6554};
		cfg_tab[3] = '{0, 5898240, 0, 0, 1};
		for (int i = 4; i < 6; i++) begin
			cfg_tab[i][0] = longint'($urandom_range(5898240)) - 5898240;
			cfg_tab[i][1] = longint'($urandom_range(5898240));
			cfg_tab[i][2] = $urandom_range(65536);
			cfg_tab[i][3] = $urandom_range(65536);
			cfg_tab[i][4] = ($urandom_range(1)) ? 0 : $urandom_range(655360, 1);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 83 : 0;
			recv_stall_pct = (ph == 0) ? 83 : (ph == 1) ? 10 : 0;
			for (int k = 0; k < 2; k++) begin
				load_config(cfg_tab[ph * 2 + k][0], cfg_tab[ph * 2 + k][1],
					cfg_tab[ph * 2 + k][2], cfg_tab[ph * 2 + k][3], cfg_tab[ph * 2 + k][4]);
				run_frames(40);
				hold_until_drained(0);
				run_frames(45);
			end
		end

		hold_until_drained(SETTLE_CYCLES);
		if (board.open_frames() != 0) begin
			board.errors += board.open_frames();
			$display("%0d expected results never arrived", board.open_frames());
		end
		if (board.errors == 0) begin
			$display("roll_angle_smoother_test: done, clean");
		end else begin
			$display("roll_angle_smoother_test: done, errors");
		end
		$finish;
	end

endmodule
